>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame statistics block.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/swfs_pkg.sv
// Shared types and constants for the sliding window frame statistics block.
// No dependencies.
package swfs_pkg;
  localparam int unsigned FtW = 20;
  localparam int unsigned CntW = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATE, ST_RDWAIT, ST_SCAN, ST_MEANDIV, ST_VMUL, ST_VDIV,
    ST_SORT, ST_SORTW, ST_OUT
  } state_e;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
endpackage

>>> rtl/swfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swfs_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/swfs_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// No dependencies.
module swfs_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

>>> rtl/sliding_window_frame_stats.sv
// Top level of the sliding window frame statistics block.
// Depends on swfs_pkg, swfs_ram, swfs_div and assert_macros.svh.
//
// Usage: drive cmd_i and its fields with start_i while busy_o is low; the
// request is taken at that edge. cmd 0 stores frame_time_us_i in the sample
// ring (oldest entry overwritten once full), may refresh the frame rate, and
// reports mean, min, max and sample variance. cmd 1 reports the same and the
// sample at the requested percentile of the sorted window.
// One result per request appears for exactly one cycle with valid_o high;
// the receiver cannot stall it, so no output buffering is needed.
// Steps from accept to result: an add scans the window, divides for the
// mean if the window is not empty and for the variance once it holds
// two or more samples; a rate refresh adds a divide before the scan. A
// query skips the rate step and adds the percentile search: up to n
// candidates, each ranked by a full pass over the single ring read port.
// busy_o drops the cycle after the result, so one request is in flight.
// Configuration: cfg_valid_i/cfg_ready_o write rate_interval_ms (reset 1000);
// ready is always high, writes are expected while the block is idle.
// Reset: write slot, fill count, frame counter, rate and timestamp clear;
// ring contents stay undefined but are only read where written.
module sliding_window_frame_stats #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   cmd_i,
  input  logic [19:0]            frame_time_us_i,
  input  logic [31:0]            now_ms_i,
  input  logic [6:0]             percentile_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [15:0]            cfg_data_i,
  output logic                   valid_o,
  output logic [27:0]            mean_q8_o,
  output logic [19:0]            min_time_o,
  output logic [19:0]            max_time_o,
  output logic [39:0]            variance_o,
  output logic [31:0]            rate_q8_o,
  output logic [6:0]             valid_count_o,
  output logic [19:0]            percentile_value_o
);
  import swfs_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned NW = $clog2(WINDOW_DEPTH + 1);
  // floor(x / 100) = (x * PctRecip) >> 24, exact for x below 199728
  localparam int unsigned PctRecip = 167773;

  state_e state_q, state_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [NW-1:0] fill_q, fill_d;
  logic [31:0]   frames_q, frames_d, last_q, last_d, rate_q, rate_d;
  logic [15:0]   intv_q;
  logic          cmd_q;
  logic [31:0]   now_q;
  logic [6:0]    pct_q;

  // scan and sort indices
  logic [NW-1:0] idx_q, idx_d;   // read address counter
  logic [NW-1:0] oi_q, oi_d;     // outer element for rank counting
  logic [NW-1:0] lt_q, lt_d, le_q, le_d;
  logic [19:0]   cand_q, cand_d;
  logic [NW-1:0] target_q, target_d;

  // sum of up to 1024 20-bit samples
  logic [29:0]   sum_q, sum_d;
  logic [63:0]   sq_q, sq_d;
  logic [19:0]   lo_q, lo_d, hi_q, hi_d, pv_q, pv_d;
  logic [39:0]   x2;
  logic [63:0]   vnum_q, vnum_d;
  logic [27:0]   mean_q, mean_d;
  logic [39:0]   var_q, var_d;
  logic          valid_q, valid_d;

  logic          we;
  logic [AW-1:0] raddr;
  logic [19:0]   rdata;

  swfs_ram #(.Width(FtW), .Depth(WINDOW_DEPTH)) u_ring (
    .clk_i, .we_i(we), .waddr_i(slot_q), .wdata_i(frame_time_us_i),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic        dstart, ddone;
  logic [63:0] dnum, dquo;
  logic [31:0] dden;

  swfs_div #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign we = accept && (cmd_i == CMD_ADD);
  assign cfg_ready_o = 1'b1;

  logic [31:0] elapsed;
  logic [15:0] intv_eff;
  assign elapsed = now_q - last_q;
  assign intv_eff = (intv_q == 16'd0) ? 16'd1 : intv_q;
  assign x2 = rdata * rdata;

  // square of the sum and n*(n-1), both fit 64 bits for n up to 1024
  logic [63:0] nsq, ssq;
  logic [NW+NW-1:0] nn1;
  assign nsq = 64'(fill_q) * sq_q;
  assign ssq = 64'(sum_q) * 64'(sum_q);
  assign nn1 = fill_q * (fill_q - 1'b1);

  logic [NW+6:0]  pn;
  logic [NW+6:0]  pidx;
  logic [NW+24:0] pmul;
  assign pn = pct_q * fill_q;
  assign pmul = (NW+25)'(pn) * (NW+25)'(PctRecip);
  assign pidx = (NW+7)'(pmul[NW+24:24]);

  always_comb begin
    state_d = state_q;
    slot_d = slot_q; fill_d = fill_q; frames_d = frames_q;
    last_d = last_q; rate_d = rate_q;
    idx_d = idx_q; oi_d = oi_q; lt_d = lt_q; le_d = le_q; cand_d = cand_q;
    target_d = target_q;
    sum_d = sum_q; sq_d = sq_q; lo_d = lo_q; hi_d = hi_q; pv_d = pv_q;
    vnum_d = vnum_q; mean_d = mean_q; var_d = var_q;
    valid_d = 1'b0;
    raddr = idx_q[AW-1:0];
    dstart = 1'b0; dnum = '0; dden = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_ADD) begin
            slot_d = (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
            if (fill_q != NW'(WINDOW_DEPTH)) fill_d = fill_q + 1'b1;
            frames_d = frames_q + 32'd1;
            state_d = ST_RATE;
          end else begin
            state_d = ST_RDWAIT;
          end
          idx_d = '0; oi_d = '0;
          sum_d = '0; sq_d = '0; lo_d = '0; hi_d = '0; pv_d = '0;
        end
      end
      ST_RATE: begin
        // divider start when interval is met; otherwise go scan
        if (!dstart && elapsed >= {16'd0, intv_eff} && !ddone && idx_q == '0
            && oi_q == '0) begin
          dstart = 1'b1;
          dnum = 64'(frames_q) * 64'd256000;
          dden = elapsed;
          oi_d = NW'(1);
        end else if (oi_q == '0) begin
          state_d = ST_RDWAIT;
        end else if (ddone) begin
          rate_d = (dquo[63:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];
          frames_d = '0;
          last_d = now_q;
          oi_d = '0;
          state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        if (fill_q == '0) begin
          state_d = ST_OUT;
          mean_d = '0; var_d = '0;
          valid_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // rdata holds entry idx_q-1
        sum_d = sum_q + 30'(rdata);
        sq_d = sq_q + 64'(x2);
        if (idx_q == NW'(1) || rdata < lo_q) lo_d = rdata;
        if (idx_q == NW'(1) || rdata > hi_q) hi_d = rdata;
        if (idx_q == fill_q) begin
          state_d = ST_MEANDIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MEANDIV: begin
        if (!ddone && oi_q == '0) begin
          dstart = 1'b1;
          dnum = 64'({sum_q, 8'd0});
          dden = 32'(fill_q);
          oi_d = NW'(1);
        end else if (ddone) begin
          mean_d = dquo[27:0];
          oi_d = '0;
          state_d = ST_VMUL;
        end
      end
      ST_VMUL: begin
        vnum_d = nsq - ssq;
        if (fill_q < NW'(2)) begin
          var_d = '0;
          state_d = (cmd_q == CMD_QUERY) ? ST_SORT : ST_OUT;
          oi_d = '0; idx_d = '0;
          target_d = (pidx > (NW+7)'(fill_q - 1'b1)) ? fill_q - 1'b1
                                                    : pidx[NW-1:0];
          valid_d = (cmd_q == CMD_ADD);
        end else begin
          state_d = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (!ddone && oi_q == '0) begin
          dstart = 1'b1;
          dnum = vnum_q;
          dden = 32'(nn1);
          oi_d = NW'(1);
        end else if (ddone) begin
          var_d = dquo[39:0];
          oi_d = '0; idx_d = '0;
          target_d = (pidx > (NW+7)'(fill_q - 1'b1)) ? fill_q - 1'b1
                                                    : pidx[NW-1:0];
          if (cmd_q == CMD_QUERY) begin
            state_d = ST_SORT;
          end else begin
            state_d = ST_OUT;
            valid_d = 1'b1;
          end
        end
      end
      ST_SORT: begin
        // fetch candidate element oi_q
        raddr = oi_q[AW-1:0];
        idx_d = '0; lt_d = '0; le_d = '0;
        state_d = ST_SORTW;
      end
      ST_SORTW: begin
        // idx_q==0: rdata is the candidate; then rdata is entry idx_q-1
        if (idx_q == '0) begin
          cand_d = rdata;
          idx_d = idx_q + 1'b1;
          raddr = '0;
        end else begin
          raddr = idx_q[AW-1:0];
          if (rdata < cand_q) lt_d = lt_q + 1'b1;
          if (rdata <= cand_q) le_d = le_q + 1'b1;
          if (idx_q == fill_q) begin
            if (target_q >= lt_d && target_q < le_d) begin
              pv_d = cand_q;
              state_d = ST_OUT;
              valid_d = 1'b1;
            end else begin
              oi_d = oi_q + 1'b1;
              state_d = ST_SORT;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q <= '0; fill_q <= '0; frames_q <= '0; last_q <= '0; rate_q <= '0;
      intv_q <= 16'd1000;
      idx_q <= '0; oi_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q <= slot_d; fill_q <= fill_d; frames_q <= frames_d;
      last_q <= last_d; rate_q <= rate_d;
      if (cfg_valid_i && cfg_ready_o) intv_q <= cfg_data_i;
      idx_q <= idx_d; oi_q <= oi_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i; now_q <= now_ms_i; pct_q <= percentile_i;
    end
    lt_q <= lt_d; le_q <= le_d; cand_q <= cand_d; target_q <= target_d;
    sum_q <= sum_d; sq_q <= sq_d; lo_q <= lo_d; hi_q <= hi_d; pv_q <= pv_d;
    vnum_q <= vnum_d; mean_q <= mean_d; var_q <= var_d;
  end

  assign valid_o = valid_q;
  assign mean_q8_o = mean_q;
  assign min_time_o = lo_q;
  assign max_time_o = hi_q;
  assign variance_o = var_q;
  assign rate_q8_o = rate_q;
  assign valid_count_o = CntW'(fill_q);
  assign percentile_value_o = pv_q;

  `ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= NW'(WINDOW_DEPTH))
  `ASSERT_NEXT(a_out_idle, clk_i, rst_ni, valid_d, state_q == ST_OUT)
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !we)
  `ASSERT_IMPL(a_lt_le, clk_i, rst_ni, state_q == ST_SORTW, lt_q <= le_q)
endmodule

>>> test/sliding_window_frame_stats_tb.sv
// Self-checking testbench for sliding_window_frame_stats: drives add and
// percentile requests plus interval writes, predicts every result and compares.
// Depends on swfs_pkg and the block's RTL.
module sliding_window_frame_stats_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swfs_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned RandItems = 1200;
  localparam int unsigned CycleLimit = 40_000_000;

  typedef struct packed {
    logic [27:0] mean_q8;
    logic [19:0] min_time;
    logic [19:0] max_time;
    logic [39:0] variance;
    logic [31:0] rate_q8;
    logic [6:0]  valid_count;
    logic [19:0] percentile_value;
  } frame_stats_t;

  // Scoreboard: own copy of the window, rate state and interval, plus the
  // queue of stats still owed by the block.
  class frame_stats_board;
    logic [19:0]  ring [Depth];
    int unsigned  wr_slot;
    int unsigned  fill;
    logic [31:0]  frames;
    logic [31:0]  last_ms;
    logic [31:0]  rate;
    logic [15:0]  interval_ms;
    frame_stats_t owed [$];
    int unsigned  errors;

    function void clear();
      wr_slot = 0; fill = 0; frames = 0; last_ms = 0; rate = 0;
      interval_ms = 16'd1000;
      errors = 0;
      owed.delete();
    endfunction

    function frame_stats_t window_stats();
      frame_stats_t s;
      longint unsigned sum, sum_sq, num;
      logic [19:0] lo, hi;
      s = '0; sum = 0; sum_sq = 0; lo = '0; hi = '0;
      for (int i = 0; i < fill; i++) begin
        sum += ring[i];
        sum_sq += longint'(ring[i]) * longint'(ring[i]);
        if (i == 0 || ring[i] < lo) lo = ring[i];
        if (i == 0 || ring[i] > hi) hi = ring[i];
      end
      if (fill != 0) s.mean_q8 = 28'((sum << 8) / fill);
      s.min_time = lo;
      s.max_time = hi;
      if (fill >= 2) begin
        num = longint'(fill) * sum_sq - sum * sum;
        s.variance = 40'(num / (longint'(fill) * longint'(fill - 1)));
      end
      s.rate_q8 = rate;
      s.valid_count = fill[6:0];
      return s;
    endfunction

    function logic [19:0] pick_percentile(logic [6:0] pct);
      logic [19:0] srt [Depth];
      logic [19:0] v;
      int j;
      int unsigned idx;
      if (fill == 0) return '0;
      for (int i = 0; i < fill; i++) begin
        v = ring[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      idx = (int'(pct) * fill) / 100;
      if (idx > fill - 1) idx = fill - 1;
      return srt[idx];
    endfunction

    // Called on every accepted request.
    function void note_request(logic cmd, logic [19:0] ft, logic [31:0] now_ms,
                               logic [6:0] pct);
      frame_stats_t s;
      logic [31:0] elapsed, ivl;
      longint unsigned r;
      if (cmd == CMD_ADD) begin
        ring[wr_slot] = ft;
        wr_slot = (wr_slot + 1 >= Depth) ? 0 : wr_slot + 1;
        if (fill < Depth) fill++;
        frames = frames + 1;
        elapsed = now_ms - last_ms;
        ivl = (interval_ms == 0) ? 32'd1 : 32'(interval_ms);
        if (elapsed >= ivl) begin
          r = (longint'(frames) * 256000) / elapsed;
          rate = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
          frames = 0;
          last_ms = now_ms;
        end
        s = window_stats();
      end else begin
        s = window_stats();
        s.percentile_value = pick_percentile(pct);
      end
      owed.push_back(s);
    endfunction

    function void check_result(frame_stats_t got);
      frame_stats_t w;
      if (owed.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.mean_q8 !== w.mean_q8) begin
        $error("mean_q8 exp %0d got %0d", w.mean_q8, got.mean_q8); errors++;
      end
      if (got.min_time !== w.min_time) begin
        $error("min_time exp %0d got %0d", w.min_time, got.min_time); errors++;
      end
      if (got.max_time !== w.max_time) begin
        $error("max_time exp %0d got %0d", w.max_time, got.max_time); errors++;
      end
      if (got.variance !== w.variance) begin
        $error("variance exp %0d got %0d", w.variance, got.variance); errors++;
      end
      if (got.rate_q8 !== w.rate_q8) begin
        $error("rate_q8 exp %0d got %0d", w.rate_q8, got.rate_q8); errors++;
      end
      if (got.valid_count !== w.valid_count) begin
        $error("valid_count exp %0d got %0d", w.valid_count, got.valid_count);
        errors++;
      end
      if (got.percentile_value !== w.percentile_value) begin
        $error("percentile_value exp %0d got %0d", w.percentile_value,
               got.percentile_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic        cmd_i;
  logic [19:0] frame_time_us_i;
  logic [31:0] now_ms_i;
  logic [6:0]  percentile_i;
  logic        cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        valid_o;
  logic [27:0] mean_q8_o;
  logic [19:0] min_time_o, max_time_o, percentile_value_o;
  logic [39:0] variance_o;
  logic [31:0] rate_q8_o;
  logic [6:0]  valid_count_o;

  frame_stats_board board;
  logic [31:0] clock_ms;   // running timestamp fed to adds
  bit          gaps_on;    // random idle cycles between requests

  sliding_window_frame_stats #(.WINDOW_DEPTH(Depth)) u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far above the slowest legal run (full-window queries dominate).
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Results live one cycle and cannot be held off: check on every strobe.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      board.check_result({mean_q8_o, min_time_o, max_time_o, variance_o,
                          rate_q8_o, valid_count_o, percentile_value_o});
  end

  // Entered and left at a falling edge. start_i stays high on exit so the
  // next request can follow back to back.
  task automatic send_request(logic cmd, logic [19:0] ft, logic [31:0] now_ms,
                              logic [6:0] pct);
    if (gaps_on && $urandom_range(99) < 14) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    cmd_i = cmd;
    frame_time_us_i = ft;
    now_ms_i = now_ms;
    percentile_i = pct;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    board.note_request(cmd, ft, now_ms, pct);
    @(negedge clk_i);
  endtask

  task automatic add_frame(logic [19:0] ft, logic [31:0] step_ms);
    clock_ms = clock_ms + step_ms;
    send_request(CMD_ADD, ft, clock_ms, 7'($urandom_range(127)));
  endtask

  // Wait until every owed result is back, plus slack for a trailing cycle.
  task automatic drain();
    start_i = 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_interval(logic [15:0] ms);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = ms;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    board.interval_ms = ms;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly adds with a drifting clock; some queries with any percentile,
  // above 100 included. Time steps span sub-interval to wrap-around jumps.
  task automatic random_traffic(int unsigned count);
    logic [31:0] step;
    logic [19:0] ft;
    for (int unsigned k = 0; k < count; k++) begin
      gaps_on = !(k >= count / 3 && k < count / 2);
      if ($urandom_range(99) < 15) begin
        send_request(CMD_QUERY, 20'($urandom), clock_ms, 7'($urandom_range(127)));
      end else begin
        case ($urandom_range(9))
          0:       step = $urandom;
          1, 2:    step = $urandom_range(70000);
          default: step = $urandom_range(40);
        endcase
        ft = ($urandom_range(3) == 0) ? 20'($urandom_range(40000)) : 20'($urandom);
        add_frame(ft, step);
      end
    end
  endtask

  initial begin
    board = new();
    board.clear();
    clock_ms = '0;
    gaps_on = 1'b1;
    start_i = 1'b0;
    cmd_i = CMD_ADD;
    frame_time_us_i = '0;
    now_ms_i = '0;
    percentile_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty window, single sample, field extremes, clamped
    // percentile, timestamp wrap and the rate refresh at the default interval.
    send_request(CMD_QUERY, 20'hFFFFF, 32'hFFFF_FFFF, 7'd0);
    send_request(CMD_QUERY, '0, '0, 7'd127);
    add_frame(20'd0, 32'd0);
    send_request(CMD_QUERY, '0, clock_ms, 7'd50);
    add_frame(20'hFFFFF, 32'd999);
    add_frame(20'd1, 32'd1);
    add_frame(20'd16667, 32'd5);
    add_frame(20'hAAAAA, 32'd3000);
    add_frame(20'h55555, 32'd0);
    send_request(CMD_QUERY, '0, clock_ms, 7'd0);
    send_request(CMD_QUERY, '0, clock_ms, 7'd100);
    send_request(CMD_QUERY, '0, clock_ms, 7'd101);
    send_request(CMD_QUERY, '0, clock_ms, 7'd127);
    send_request(CMD_QUERY, '0, clock_ms, 7'h2A);
    send_request(CMD_QUERY, '0, clock_ms, 7'h55);
    add_frame(20'd33333, 32'hFFFF_FFFF - clock_ms);
    add_frame(20'd8000, 32'd2000);
    add_frame(20'd8000, 32'd0);

    // Random phases across interval settings, both extremes and zero.
    random_traffic(RandItems / 4);
    write_interval(16'd1);
    random_traffic(RandItems / 4);
    write_interval(16'hFFFF);
    add_frame(20'd12345, 32'd70000);
    random_traffic(RandItems / 8);
    write_interval(16'd0);
    random_traffic(RandItems / 8);
    write_interval(16'($urandom_range(2, 2000)));
    random_traffic(RandItems / 4);

    drain();
    repeat (50) @(negedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (board.owed.size() != 0) $error("%0d results never came", board.owed.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/swfs_pkg.sv
rtl/swfs_ram.sv
rtl/swfs_div.sv
rtl/sliding_window_frame_stats.sv
test/sliding_window_frame_stats_tb.sv
